// ===== rtl/core/apu_pkg.sv =====
package apu_pkg;

	localparam int NUM_NODES   = 1024;
	localparam int DIMENSION   = 4;
	localparam int ELEM_COUNT  = NUM_NODES * DIMENSION;
	localparam int IDX_W       = 12;
	localparam int STORE_DEPTH = 1 << IDX_W;
	localparam int FM_W        = 32;
	localparam int SM_W        = 48;
	localparam int ENTRY_W     = FM_W + SM_W;
	localparam int ACC_W       = 98;
	localparam int MUL_W       = 33;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int NUM_W       = 96;
	localparam int DEN_W       = 49;
	localparam int CNT_W       = 7;
	localparam int SQ_CNT_W    = 5;

	localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
	localparam logic [31:0] LR_RST    = 32'd16777;
	localparam logic [31:0] COOL_RST  = 32'h8000_0000;
	localparam logic [31:0] B1_RST    = 32'd1932735283;
	localparam logic [31:0] B2_RST    = 32'd2145336164;
	localparam logic [31:0] STAB_RST  = 32'd43;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef enum logic [2:0] {
		REG_LR,
		REG_COOL,
		REG_B1,
		REG_B2,
		REG_STAB
	} cfg_reg_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_START,
		S_P1, S_P2, S_PC, S_PW1, S_PW2,
		S_RD, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9,
		S_WB, S_DW1, S_DW2, S_SQ, S_SQW, S_DEN, S_DW3,
		S_R1, S_R2, S_R3, S_R4, S_PASS, S_OUT
	} state_t;

	typedef enum logic [3:0] {
		MS_P1, MS_P2, MS_PC, MS_FM, MS_G1, MS_GG, MS_SMLO, MS_SMHI,
		MS_GSLO, MS_GSHI, MS_SC, MS_RLO, MS_RHI
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef enum logic [3:0] {
		CAP_NONE, CAP_P1, CAP_P2, CAP_PC, CAP_M, CAP_GSQ, CAP_V1, CAP_V,
		CAP_SC, CAP_MHAT, CAP_VHAT, CAP_DEN, CAP_RATIO, CAP_STEP, CAP_PASS
	} cap_t;

	typedef enum logic [1:0] {
		DV_MHAT,
		DV_VHAT,
		DV_RATIO
	} div_sel_t;

	typedef struct packed {
		logic                 op;
		logic [IDX_W-1:0]     element_index;
		logic                 first_of_pass;
		logic signed [31:0]   gradient;
		logic signed [31:0]   current_parameter;
	} in_t;

	typedef struct packed {
		logic signed [31:0]   updated_parameter;
		logic [IDX_W-1:0]     result_index;
	} out_t;

	typedef struct packed {
		logic             load_in;
		logic             pow_reset;
		mul_sel_t         mul_sel;
		acc_op_t          acc_op;
		logic             sh32;
		cap_t             cap;
		logic             mem_rd;
		logic             mem_wr;
		logic             clr_mode;
		logic [IDX_W-1:0] clr_addr;
		logic             div_start;
		div_sel_t         div_sel;
		logic             sqrt_start;
		logic             out_load;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic first;
		logic inrange;
		logic dzero;
		logic den_zero;
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/apu_div.sv =====
module apu_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [apu_pkg::NUM_W-1:0]   num,
	input  logic [apu_pkg::DEN_W-1:0]   den,
	output logic                        done,
	output logic [63:0]                 quo
);

	logic                        busy_q;
	logic                        done_q;
	logic [apu_pkg::CNT_W-1:0]   cnt_q;
	logic [apu_pkg::NUM_W-1:0]   nq_q;
	logic [apu_pkg::DEN_W-1:0]   rem_q;
	logic [apu_pkg::DEN_W-1:0]   den_q;
	logic [apu_pkg::DEN_W:0]     trial;
	logic [apu_pkg::DEN_W:0]     diff;
	logic                        ge;

	assign trial = {rem_q, nq_q[apu_pkg::NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == apu_pkg::CNT_W'(apu_pkg::NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// restoring division, one quotient bit per cycle shifted in behind the numerator
	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			nq_q  <= {nq_q[apu_pkg::NUM_W-2:0], ge};
			rem_q <= ge ? diff[apu_pkg::DEN_W-1:0] : trial[apu_pkg::DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = (|nq_q[apu_pkg::NUM_W-1:64]) ? '1 : nq_q[63:0];

endmodule

// ===== rtl/core/apu_sqrt.sv =====
module apu_sqrt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   x,
	output logic          done,
	output logic [31:0]   root
);

	logic                          busy_q;
	logic                          done_q;
	logic [apu_pkg::SQ_CNT_W-1:0]  cnt_q;
	logic [63:0]                   x_q;
	logic [63:0]                   res_q;
	logic [63:0]                   bit_q;
	logic [63:0]                   trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (&cnt_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// two radicand bits per step, 32 steps
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

// ===== rtl/core/apu_dp.sv =====
module apu_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  apu_pkg::cmd_t              cmd,
	output apu_pkg::sts_t              sts,
	input  apu_pkg::in_t               in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output apu_pkg::out_t              out_data,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [31:0]                cfg_data
);

	localparam logic [apu_pkg::ACC_W-1:0] RND30 = apu_pkg::ACC_W'(1) << 30;
	localparam logic [apu_pkg::ACC_W-1:0] RND23 = apu_pkg::ACC_W'(1) << 23;
	localparam logic [49:0]               MAX48 = 50'h0_FFFF_FFFF_FFFF;

	logic [31:0] lr_q, cool_q, b1_q, b2_q, stab_q;
	logic [31:0] pow1_q, pow2_q, powc_q;
	logic [31:0] b1c, b2c, coolc;

	apu_pkg::in_t                   in_q;
	logic [apu_pkg::ENTRY_W-1:0]    mem_q [apu_pkg::STORE_DEPTH];
	logic [apu_pkg::ENTRY_W-1:0]    rd_q;
	logic [apu_pkg::IDX_W-1:0]      waddr;
	logic [apu_pkg::ENTRY_W-1:0]    wdata;

	logic signed [apu_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic signed [apu_pkg::PROD_W-1:0] prod_s1;
	apu_pkg::acc_op_t                  acc_op_s1;
	logic                              sh_s1;
	logic [apu_pkg::ACC_W-1:0]         acc_q, addend, acc_base;

	logic [31:0] m_q;
	logic [46:0] gsq_q;
	logic [48:0] v1_q;
	logic [47:0] v_q;
	logic [31:0] scale_q;
	logic [63:0] mhat_q, vhat_q, ratio_q;
	logic [apu_pkg::DEN_W-1:0] den_q;
	logic [31:0] res_q;
	logic        outv_q;
	apu_pkg::out_t out_q;

	logic [31:0] gmag, mmag, d1, d2;
	logic [apu_pkg::ACC_W-1:0] rnd31, acc_mag, mrnd, stp;
	logic [31:0] m_new;
	logic [49:0] vsum;
	logic [47:0] v_new;
	logic [32:0] step33;
	logic signed [34:0] sum_r;
	logic [31:0] res_new;
	logic [apu_pkg::DEN_W-1:0] den_new;

	logic [apu_pkg::NUM_W-1:0] div_num;
	logic [apu_pkg::DEN_W-1:0] div_den;
	logic [63:0]               div_quo;
	logic                      div_done;
	logic [31:0]               root;
	logic                      sqrt_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= apu_pkg::LR_RST;
			cool_q <= apu_pkg::COOL_RST;
			b1_q   <= apu_pkg::B1_RST;
			b2_q   <= apu_pkg::B2_RST;
			stab_q <= apu_pkg::STAB_RST;
		end else if (cfg_we) begin
			unique case (apu_pkg::cfg_reg_t'(cfg_index))
				apu_pkg::REG_LR:   lr_q   <= cfg_data;
				apu_pkg::REG_COOL: cool_q <= cfg_data;
				apu_pkg::REG_B1:   b1_q   <= cfg_data;
				apu_pkg::REG_B2:   b2_q   <= cfg_data;
				apu_pkg::REG_STAB: stab_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign b1c   = (b1_q > apu_pkg::ONE_Q31) ? apu_pkg::ONE_Q31 : b1_q;
	assign b2c   = (b2_q > apu_pkg::ONE_Q31) ? apu_pkg::ONE_Q31 : b2_q;
	assign coolc = (cool_q > apu_pkg::ONE_Q31) ? apu_pkg::ONE_Q31 : cool_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= in_data;
		end
	end

	// moment store: {second moment, first moment}
	assign waddr = cmd.clr_mode ? cmd.clr_addr : in_q.element_index;
	assign wdata = cmd.clr_mode ? '0 : {v_q, m_q};

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem_q[waddr] <= wdata;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem_q[in_q.element_index];
		end
	end

	assign gmag = in_q.gradient[31] ? (~in_q.gradient + 32'd1) : in_q.gradient;
	assign mmag = m_q[31] ? (~m_q + 32'd1) : m_q;
	assign d1   = apu_pkg::ONE_Q31 - pow1_q;
	assign d2   = apu_pkg::ONE_Q31 - pow2_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			apu_pkg::MS_P1: begin
				mul_a = {1'b0, pow1_q};
				mul_b = {1'b0, b1c};
			end
			apu_pkg::MS_P2: begin
				mul_a = {1'b0, pow2_q};
				mul_b = {1'b0, b2c};
			end
			apu_pkg::MS_PC: begin
				mul_a = {1'b0, powc_q};
				mul_b = {1'b0, coolc};
			end
			apu_pkg::MS_FM: begin
				mul_a = {rd_q[apu_pkg::FM_W-1], rd_q[apu_pkg::FM_W-1:0]};
				mul_b = {1'b0, b1c};
			end
			apu_pkg::MS_G1: begin
				mul_a = {in_q.gradient[31], in_q.gradient};
				mul_b = {1'b0, apu_pkg::ONE_Q31 - b1c};
			end
			apu_pkg::MS_GG: begin
				mul_a = {1'b0, gmag};
				mul_b = {1'b0, gmag};
			end
			apu_pkg::MS_SMLO: begin
				mul_a = {1'b0, rd_q[63:32]};
				mul_b = {1'b0, b2c};
			end
			apu_pkg::MS_SMHI: begin
				mul_a = {17'd0, rd_q[79:64]};
				mul_b = {1'b0, b2c};
			end
			apu_pkg::MS_GSLO: begin
				mul_a = {1'b0, gsq_q[31:0]};
				mul_b = {1'b0, apu_pkg::ONE_Q31 - b2c};
			end
			apu_pkg::MS_GSHI: begin
				mul_a = {18'd0, gsq_q[46:32]};
				mul_b = {1'b0, apu_pkg::ONE_Q31 - b2c};
			end
			apu_pkg::MS_SC: begin
				mul_a = {1'b0, powc_q};
				mul_b = {1'b0, lr_q};
			end
			apu_pkg::MS_RLO: begin
				mul_a = {1'b0, ratio_q[31:0]};
				mul_b = {1'b0, scale_q};
			end
			apu_pkg::MS_RHI: begin
				mul_a = {1'b0, ratio_q[63:32]};
				mul_b = {1'b0, scale_q};
			end
			default: ;
		endcase
	end

	// product registered, then accumulated in the cycle after
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		sh_s1   <= cmd.sh32;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_op_s1 <= apu_pkg::ACC_NONE;
		end else begin
			acc_op_s1 <= cmd.acc_op;
		end
	end

	assign addend = sh_s1
		? ({{(apu_pkg::ACC_W - apu_pkg::PROD_W){prod_s1[apu_pkg::PROD_W-1]}}, prod_s1} << 32)
		: {{(apu_pkg::ACC_W - apu_pkg::PROD_W){prod_s1[apu_pkg::PROD_W-1]}}, prod_s1};
	assign acc_base = (acc_op_s1 == apu_pkg::ACC_LOAD) ? '0 : acc_q;

	always_ff @(posedge clk) begin
		if (acc_op_s1 != apu_pkg::ACC_NONE) begin
			acc_q <= acc_base + addend;
		end
	end

	// result shaping from the accumulator
	assign rnd31   = (acc_q + RND30) >> 31;
	assign acc_mag = acc_q[apu_pkg::ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
	assign mrnd    = (acc_mag + RND30) >> 31;
	assign m_new   = acc_q[apu_pkg::ACC_W-1] ? (~mrnd[31:0] + 32'd1) : mrnd[31:0];
	assign vsum    = {1'b0, v1_q} + {1'b0, rnd31[48:0]};
	assign v_new   = (vsum > MAX48) ? MAX48[47:0] : vsum[47:0];
	assign stp     = (acc_q + RND23) >> 24;
	assign step33  = (stp > apu_pkg::ACC_W'(33'h1_0000_0000)) ? 33'h1_0000_0000 : stp[32:0];
	assign sum_r   = m_q[31]
		? ({{3{in_q.current_parameter[31]}}, in_q.current_parameter} - {2'b00, step33})
		: ({{3{in_q.current_parameter[31]}}, in_q.current_parameter} + {2'b00, step33});

	always_comb begin
		if (sum_r > 35'sd2147483647) begin
			res_new = 32'h7FFF_FFFF;
		end else if (sum_r < -35'sd2147483648) begin
			res_new = 32'h8000_0000;
		end else begin
			res_new = sum_r[31:0];
		end
	end

	assign den_new = {1'b0, root, 16'd0} + {17'd0, stab_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pow1_q <= apu_pkg::ONE_Q31;
			pow2_q <= apu_pkg::ONE_Q31;
			powc_q <= apu_pkg::ONE_Q31;
		end else if (cmd.pow_reset) begin
			pow1_q <= apu_pkg::ONE_Q31;
			pow2_q <= apu_pkg::ONE_Q31;
			powc_q <= apu_pkg::ONE_Q31;
		end else begin
			case (cmd.cap)
				apu_pkg::CAP_P1: pow1_q <= rnd31[31:0];
				apu_pkg::CAP_P2: pow2_q <= rnd31[31:0];
				apu_pkg::CAP_PC: powc_q <= rnd31[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.cap)
			apu_pkg::CAP_M:     m_q     <= m_new;
			apu_pkg::CAP_GSQ:   gsq_q   <= acc_q[62:16];
			apu_pkg::CAP_V1:    v1_q    <= rnd31[48:0];
			apu_pkg::CAP_V:     v_q     <= v_new;
			apu_pkg::CAP_SC:    scale_q <= rnd31[31:0];
			apu_pkg::CAP_MHAT:  mhat_q  <= div_quo;
			apu_pkg::CAP_VHAT:  vhat_q  <= div_quo;
			apu_pkg::CAP_DEN:   den_q   <= den_new;
			apu_pkg::CAP_RATIO: ratio_q <= div_quo;
			apu_pkg::CAP_STEP:  res_q   <= res_new;
			apu_pkg::CAP_PASS:  res_q   <= in_q.current_parameter;
			default: ;
		endcase
	end

	always_comb begin
		div_num = '0;
		div_den = '0;
		case (cmd.div_sel)
			apu_pkg::DV_MHAT: begin
				div_num = apu_pkg::NUM_W'(mmag) << 31;
				div_den = {17'd0, d1};
			end
			apu_pkg::DV_VHAT: begin
				div_num = apu_pkg::NUM_W'(v_q) << 47;
				div_den = {17'd0, d2};
			end
			apu_pkg::DV_RATIO: begin
				div_num = apu_pkg::NUM_W'(mhat_q) << 32;
				div_den = den_q;
			end
			default: ;
		endcase
	end

	apu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	apu_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.x      (vhat_q),
		.done   (sqrt_done),
		.root   (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outv_q <= 1'b0;
		end else if (cmd.out_load) begin
			outv_q <= 1'b1;
		end else if (out_ready) begin
			outv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.updated_parameter <= res_q;
			out_q.result_index      <= in_q.element_index;
		end
	end

	assign out_valid = outv_q;
	assign out_data  = out_q;

	assign sts.op        = in_q.op;
	assign sts.first     = in_q.first_of_pass;
	assign sts.inrange   = {1'b0, in_q.element_index} < (apu_pkg::IDX_W + 1)'(apu_pkg::ELEM_COUNT);
	assign sts.dzero     = (pow1_q == apu_pkg::ONE_Q31) || (pow2_q == apu_pkg::ONE_Q31);
	assign sts.den_zero  = (den_q == '0);
	assign sts.div_done  = div_done;
	assign sts.sqrt_done = sqrt_done;
	assign sts.out_free  = !outv_q || out_ready;

endmodule

// ===== rtl/core/apu_ctrl.sv =====
module apu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  apu_pkg::sts_t  sts,
	output apu_pkg::cmd_t  cmd
);

	apu_pkg::state_t               state_q, state_d;
	logic [apu_pkg::IDX_W-1:0]     clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= apu_pkg::S_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == apu_pkg::S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end else begin
				clr_cnt_q <= '0;
			end
		end
	end

	assign in_ready = (state_q == apu_pkg::S_IDLE);

	// multiplier results pass the product register and then the accumulator before capture
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.mul_sel    = apu_pkg::MS_P1;
		cmd.acc_op     = apu_pkg::ACC_NONE;
		cmd.cap        = apu_pkg::CAP_NONE;
		cmd.div_sel    = apu_pkg::DV_MHAT;
		cmd.clr_addr   = clr_cnt_q;
		cmd.load_in    = in_valid && in_ready;
		unique case (state_q)
			apu_pkg::S_CLEAR: begin
				cmd.mem_wr    = 1'b1;
				cmd.clr_mode  = 1'b1;
				cmd.pow_reset = 1'b1;
				if (clr_cnt_q == apu_pkg::IDX_W'(apu_pkg::STORE_DEPTH - 1)) begin
					state_d = apu_pkg::S_IDLE;
				end
			end
			apu_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = apu_pkg::S_START;
				end
			end
			apu_pkg::S_START: begin
				if (sts.op == apu_pkg::OP_CLEAR) begin
					state_d = apu_pkg::S_CLEAR;
				end else if (sts.first) begin
					state_d = apu_pkg::S_P1;
				end else if (sts.inrange) begin
					state_d = apu_pkg::S_RD;
				end else begin
					state_d = apu_pkg::S_PASS;
				end
			end
			apu_pkg::S_P1: begin
				cmd.mul_sel = apu_pkg::MS_P1;
				cmd.acc_op  = apu_pkg::ACC_LOAD;
				state_d     = apu_pkg::S_P2;
			end
			apu_pkg::S_P2: begin
				cmd.mul_sel = apu_pkg::MS_P2;
				cmd.acc_op  = apu_pkg::ACC_LOAD;
				state_d     = apu_pkg::S_PC;
			end
			apu_pkg::S_PC: begin
				cmd.mul_sel = apu_pkg::MS_PC;
				cmd.acc_op  = apu_pkg::ACC_LOAD;
				cmd.cap     = apu_pkg::CAP_P1;
				state_d     = apu_pkg::S_PW1;
			end
			apu_pkg::S_PW1: begin
				cmd.cap = apu_pkg::CAP_P2;
				state_d = apu_pkg::S_PW2;
			end
			apu_pkg::S_PW2: begin
				cmd.cap = apu_pkg::CAP_PC;
				state_d = sts.inrange ? apu_pkg::S_RD : apu_pkg::S_PASS;
			end
			apu_pkg::S_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = apu_pkg::S_M1;
			end
			apu_pkg::S_M1: begin
				cmd.mul_sel = apu_pkg::MS_FM;
				cmd.acc_op  = apu_pkg::ACC_LOAD;
				state_d     = apu_pkg::S_M2;
			end
			apu_pkg::S_M2: begin
				cmd.mul_sel = apu_pkg::MS_G1;
				cmd.acc_op  = apu_pkg::ACC_ADD;
				state_d     = apu_pkg::S_M3;
			end
			apu_pkg::S_M3: begin
				cmd.mul_sel = apu_pkg::MS_GG;
				cmd.acc_op  = apu_pkg::ACC_LOAD;
				state_d     = apu_pkg::S_M4;
			end
			apu_pkg::S_M4: begin
				cmd.cap     = apu_pkg::CAP_M;
				cmd.mul_sel = apu_pkg::MS_SMLO;
				cmd.acc_op  = apu_pkg::ACC_LOAD;
				state_d     = apu_pkg::S_M5;
			end
			apu_pkg::S_M5: begin
				cmd.cap     = apu_pkg::CAP_GSQ;
				cmd.mul_sel = apu_pkg::MS_SMHI;
				cmd.acc_op  = apu_pkg::ACC_ADD;
				cmd.sh32    = 1'b1;
				state_d     = apu_pkg::S_M6;
			end
			apu_pkg::S_M6: begin
				cmd.mul_sel = apu_pkg::MS_GSLO;
				cmd.acc_op  = apu_pkg::ACC_LOAD;
				state_d     = apu_pkg::S_M7;
			end
			apu_pkg::S_M7: begin
				cmd.cap     = apu_pkg::CAP_V1;
				cmd.mul_sel = apu_pkg::MS_GSHI;
				cmd.acc_op  = apu_pkg::ACC_ADD;
				cmd.sh32    = 1'b1;
				state_d     = apu_pkg::S_M8;
			end
			apu_pkg::S_M8: begin
				cmd.mul_sel = apu_pkg::MS_SC;
				cmd.acc_op  = apu_pkg::ACC_LOAD;
				state_d     = apu_pkg::S_M9;
			end
			apu_pkg::S_M9: begin
				cmd.cap = apu_pkg::CAP_V;
				state_d = apu_pkg::S_WB;
			end
			apu_pkg::S_WB: begin
				cmd.mem_wr = 1'b1;
				cmd.cap    = apu_pkg::CAP_SC;
				if (sts.dzero) begin
					state_d = apu_pkg::S_PASS;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = apu_pkg::DV_MHAT;
					state_d       = apu_pkg::S_DW1;
				end
			end
			apu_pkg::S_DW1: begin
				if (sts.div_done) begin
					cmd.cap       = apu_pkg::CAP_MHAT;
					cmd.div_start = 1'b1;
					cmd.div_sel   = apu_pkg::DV_VHAT;
					state_d       = apu_pkg::S_DW2;
				end
			end
			apu_pkg::S_DW2: begin
				if (sts.div_done) begin
					cmd.cap = apu_pkg::CAP_VHAT;
					state_d = apu_pkg::S_SQ;
				end
			end
			apu_pkg::S_SQ: begin
				cmd.sqrt_start = 1'b1;
				state_d        = apu_pkg::S_SQW;
			end
			apu_pkg::S_SQW: begin
				if (sts.sqrt_done) begin
					cmd.cap = apu_pkg::CAP_DEN;
					state_d = apu_pkg::S_DEN;
				end
			end
			apu_pkg::S_DEN: begin
				if (sts.den_zero) begin
					state_d = apu_pkg::S_PASS;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = apu_pkg::DV_RATIO;
					state_d       = apu_pkg::S_DW3;
				end
			end
			apu_pkg::S_DW3: begin
				if (sts.div_done) begin
					cmd.cap = apu_pkg::CAP_RATIO;
					state_d = apu_pkg::S_R1;
				end
			end
			apu_pkg::S_R1: begin
				cmd.mul_sel = apu_pkg::MS_RLO;
				cmd.acc_op  = apu_pkg::ACC_LOAD;
				state_d     = apu_pkg::S_R2;
			end
			apu_pkg::S_R2: begin
				cmd.mul_sel = apu_pkg::MS_RHI;
				cmd.acc_op  = apu_pkg::ACC_ADD;
				cmd.sh32    = 1'b1;
				state_d     = apu_pkg::S_R3;
			end
			apu_pkg::S_R3: begin
				state_d = apu_pkg::S_R4;
			end
			apu_pkg::S_R4: begin
				cmd.cap = apu_pkg::CAP_STEP;
				state_d = apu_pkg::S_OUT;
			end
			apu_pkg::S_PASS: begin
				cmd.cap = apu_pkg::CAP_PASS;
				state_d = apu_pkg::S_OUT;
			end
			apu_pkg::S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = apu_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = apu_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/adam_parameter_update.sv =====
// An update runs three 96-step serial divisions and a 32-step square root, after the
// power updates on a pass start; out-of-range items skip the divisions and the root,
// and a zero bias divisor or a zero root divisor ends the update with the parameter passed through.
// Flow: one transaction at a time, the next taken once the result is registered;
// a clear transaction sweeps the moment memory before in_ready returns.
// Reset: asynchronous, active low; a sweep then zeroes all 4096 memory entries, in_ready low.
module adam_parameter_update (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  apu_pkg::in_t    in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output apu_pkg::out_t   out_data,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [31:0]     cfg_data
);

	apu_pkg::cmd_t cmd;
	apu_pkg::sts_t sts;

	apu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	apu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

// ===== tb/sv/apu_checker.sv =====
`timescale 1ns / 1ps

module apu_checker
	import apu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_t         in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_t        out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending
);

	logic [31:0] lr_q, cool_q, b1_q, b2_q, stab_q;
	logic signed [31:0] fm_store [STORE_DEPTH];
	logic [47:0]        sm_store [STORE_DEPTH];
	logic [31:0] step_cnt, b1_pow, b2_pow, cool_pow;
	out_t expected_q [$];

	function automatic logic [63:0] clamp_rate(logic [31:0] r);
		return (r > ONE_Q31) ? 64'(ONE_Q31) : 64'(r);
	endfunction

	// rounded (a*b) >> s, saturated to 64 bits
	function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int s);
		logic [128:0] p;
		p = {65'd0, a} * {65'd0, b};
		p = p + (129'd1 << (s - 1));
		p = p >> s;
		if (p[128:64] != 0)
			return '1;
		return p[63:0];
	endfunction

	// floor(num * 2^sh / d), saturated to 64 bits
	function automatic logic [63:0] div_frac(logic [63:0] num, int sh, logic [63:0] d);
		logic [127:0] n, q;
		n = {64'd0, num} << sh;
		q = n / {64'd0, d};
		if (q[127:64] != 0)
			return '1;
		return q[63:0];
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > x)
			bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (x >= res + bit_v) begin
				x = x - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	task automatic clear_moments();
		for (int i = 0; i < STORE_DEPTH; i++) begin
			fm_store[i] = '0;
			sm_store[i] = '0;
		end
		step_cnt = '0;
		b1_pow = ONE_Q31;
		b2_pow = ONE_Q31;
		cool_pow = ONE_Q31;
	endtask

	task automatic predict_update(input in_t t);
		logic [63:0] b1, b2, gmag, gsq, v, vt, d1, d2, mmag, mhat, vhat, den;
		logic [63:0] ratio, scale, step;
		longint g, cur, res, acc, m;
		int idx;
		out_t r;
		idx = int'(t.element_index);
		g = longint'(t.gradient);
		cur = longint'(t.current_parameter);
		res = cur;
		b1 = clamp_rate(b1_q);
		b2 = clamp_rate(b2_q);
		if (t.op == OP_CLEAR) begin
			clear_moments();
			return;
		end
		if (t.first_of_pass) begin
			step_cnt = step_cnt + 32'd1;
			b1_pow = 32'(mul_round(64'(b1_pow), b1, 31));
			b2_pow = 32'(mul_round(64'(b2_pow), b2, 31));
			cool_pow = 32'(mul_round(64'(cool_pow), clamp_rate(cool_q), 31));
		end
		if (idx < ELEM_COUNT) begin
			acc = longint'(b1) * longint'(fm_store[idx]) + longint'(64'(ONE_Q31) - b1) * g;
			if (acc >= 0)
				m = (acc + (64'sd1 <<< 30)) >>> 31;
			else
				m = -((-acc + (64'sd1 <<< 30)) >>> 31);
			gmag = (g < 0) ? -g : g;
			gsq = (gmag * gmag) >> 16;
			v = mul_round(64'(sm_store[idx]), b2, 31);
			vt = mul_round(gsq, 64'(ONE_Q31) - b2, 31);
			d1 = 64'(ONE_Q31) - 64'(b1_pow);
			d2 = 64'(ONE_Q31) - 64'(b2_pow);
			v = (v + vt > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : v + vt;
			fm_store[idx] = m[31:0];
			sm_store[idx] = v[47:0];
			if (d1 != 0 && d2 != 0) begin
				mmag = (m < 0) ? -m : m;
				mhat = div_frac(mmag, 31, d1);
				vhat = div_frac(v, 47, d2);
				den = (int_sqrt(vhat) << 16) + 64'(stab_q);
				if (den != 0) begin
					ratio = div_frac(mhat, 32, den);
					scale = mul_round(64'(cool_pow), 64'(lr_q), 31);
					step = mul_round(ratio, scale, 24);
					if (step > 64'h1_0000_0000)
						step = 64'h1_0000_0000;
					res = (m < 0) ? cur - longint'(step) : cur + longint'(step);
					if (res > 64'sd2147483647)
						res = 64'sd2147483647;
					if (res < -64'sd2147483648)
						res = -64'sd2147483648;
				end
			end
		end
		r.updated_parameter = res[31:0];
		r.result_index = t.element_index;
		expected_q.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t checker: %s got 0x%08h expected 0x%08h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			lr_q = LR_RST;
			cool_q = COOL_RST;
			b1_q = B1_RST;
			b2_q = B2_RST;
			stab_q = STAB_RST;
			clear_moments();
			expected_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LR: lr_q = cfg_data;
					REG_COOL: cool_q = cfg_data;
					REG_B1: b1_q = cfg_data;
					REG_B2: b2_q = cfg_data;
					REG_STAB: stab_q = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_update(in_data);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected transaction, parameter",
						out_data.updated_parameter, 32'h0);
				end else begin
					want = expected_q.pop_front();
					if (out_data.updated_parameter !== want.updated_parameter)
						report_mismatch("updated_parameter", out_data.updated_parameter,
							want.updated_parameter);
					if (out_data.result_index !== want.result_index)
						report_mismatch("result_index", 32'(out_data.result_index),
							32'(want.result_index));
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import apu_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_WAIT = 4200;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          errors;
	int          pending;

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_req;
	int hold_done;
	int quiet_cycles;

	adam_parameter_update u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	apu_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// receiver: random backpressure, plus long hold-offs on request
	initial begin
		out_ready = 1'b0;
		hold_done = 0;
		forever begin
			@(negedge clk);
			if (hold_done < hold_req) begin
				out_ready = 1'b0;
				repeat (2000) @(negedge clk);
				hold_done++;
			end
			out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic send_item(input in_t t);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = t;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
		cfg_we = 1'b1;
		cfg_index = r;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// wait for all results, then for a possible clear sweep to finish
	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic set_rates(input logic [31:0] lr, input logic [31:0] cool,
			input logic [31:0] b1, input logic [31:0] b2, input logic [31:0] stab);
		write_reg(REG_LR, lr);
		write_reg(REG_COOL, cool);
		write_reg(REG_B1, b1);
		write_reg(REG_B2, b2);
		write_reg(REG_STAB, stab);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom();
			default: return 32'($signed($urandom()) >>> $urandom_range(8, 20));
		endcase
	endfunction

	function automatic in_t make_item(input logic op, input int idx, input logic fop,
			input logic [31:0] g, input logic [31:0] cur);
		in_t t;
		t.op = op;
		t.element_index = idx[IDX_W-1:0];
		t.first_of_pass = fop;
		t.gradient = g;
		t.current_parameter = cur;
		return t;
	endfunction

	function automatic in_t random_item();
		logic op;
		int idx;
		op = ($urandom_range(0, 149) == 0) ? OP_CLEAR : OP_UPDATE;
		idx = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 15) : $urandom_range(0, 4095);
		return make_item(op, idx, $urandom_range(0, 5) == 0, pick_value(), pick_value());
	endfunction

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_item(random_item());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_LR;
		cfg_data = '0;
		tx_idle_pct = 25;
		rx_idle_pct = 71;
		hold_req = 0;
		quiet_cycles = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_rates(32'h0100_0000, 32'h7000_0000, B1_RST, B2_RST, STAB_RST);
		// no pass yet: bias divisors are zero, parameter passes through
		send_item(make_item(OP_UPDATE, 0, 1'b0, 32'h0001_0000, 32'h0002_0000));
		send_item(make_item(OP_UPDATE, 0, 1'b1, 32'h7FFF_FFFF, 32'h0));
		send_item(make_item(OP_UPDATE, 4095, 1'b0, 32'h8000_0000, 32'h0));
		send_item(make_item(OP_UPDATE, 1, 1'b0, 32'h0, 32'h7FFF_FFFF));
		send_item(make_item(OP_UPDATE, 0, 1'b1, 32'h0010_0000, 32'h7FFF_FFF0));
		send_item(make_item(OP_UPDATE, 4095, 1'b0, 32'hFFF0_0000, 32'h8000_0010));
		send_item(make_item(OP_CLEAR, 0, 1'b0, 32'h0, 32'h0));
		send_item(make_item(OP_UPDATE, 0, 1'b0, 32'h0003_0000, 32'h1234_5678));
		send_item(make_item(OP_UPDATE, 2, 1'b1, 32'hFFFF_0000, 32'h0));
		drain();

		// extremes: rates above one, zero betas, zero stabilizer, huge step
		set_rates(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
		send_item(make_item(OP_UPDATE, 3, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_0000));
		send_item(make_item(OP_UPDATE, 3, 1'b0, 32'h8000_0000, 32'h8000_FFFF));
		send_item(make_item(OP_UPDATE, 5, 1'b0, 32'h0, 32'h0000_1000));
		send_item(make_item(OP_UPDATE, 6, 1'b1, 32'h0000_0001, 32'hFFFF_FFFF));
		send_random(100);
		drain();

		set_rates(32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
		send_random(40);
		drain();

		set_rates(32'h0010_0000, 32'h7F00_0000, 32'h6000_0000, 32'h7F00_0000, STAB_RST);
		send_random(40);
		tx_idle_pct = 71;
		rx_idle_pct = 25;
		send_random(110);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req = 1;
		send_random(110);
		in_valid = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (400) @(negedge clk);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
